### design/extent_overlap_matcher_macros.svh
// Assertion macros used by the extent overlap matcher checker.
`ifndef EXTENT_OVERLAP_MATCHER_MACROS_SVH
`define EXTENT_OVERLAP_MATCHER_MACROS_SVH

// Same-cycle implication, masked while reset is low.
`define EOM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("extent_overlap_matcher: assertion failed");

// Next-cycle implication, masked while reset is low.
`define EOM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("extent_overlap_matcher: assertion failed");

// Next-cycle implication that also holds through reset.
`define EOM_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("extent_overlap_matcher: assertion failed");

`endif

### design/eom_pkg.sv
// Shared constants and types of the extent overlap matcher.
`default_nettype none
package eom_pkg;

  localparam int IDX_W       = 16;
  localparam int FIELD_W     = 32;
  localparam int MASK_W      = 64;
  localparam int IN_DIMS     = 4;
  localparam int IN_DATA_W   = IDX_W + 2 * IN_DIMS * FIELD_W;  // 272, whole bytes
  localparam int OUT_DATA_W  = 88;                             // 81 bits used
  localparam int SUB_COUNT_W = 7;
  localparam int DIM_COUNT_W = 3;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 7;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_MATCH = 1'b1;

  localparam logic [CFG_INDEX_W-1:0] REG_SUBSCRIPTION_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DIMENSION_COUNT    = 2'd1;

  // Broadcast slot write, decoded inside each cell.
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] slot;
  } load_ctl_t;

endpackage
`default_nettype wire

### design/eom_cell.sv
// One matcher cell: holds a subscription extent and tests the passing update.
`default_nettype none
module eom_cell #(
  parameter int SLOT           = 0,
  parameter int MAX_DIMENSIONS = 4,
  parameter int COORD_BITS     = 32
) (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire eom_pkg::load_ctl_t                        load_i,
  input  wire logic [MAX_DIMENSIONS-1:0][COORD_BITS-1:0] wr_lo_i,
  input  wire logic [MAX_DIMENSIONS-1:0][COORD_BITS-1:0] wr_hi_i,
  input  wire logic [MAX_DIMENSIONS-1:0]                 dim_en_i,
  input  wire logic                                      tok_i,
  input  wire logic [MAX_DIMENSIONS-1:0][COORD_BITS-1:0] lo_i,
  input  wire logic [MAX_DIMENSIONS-1:0][COORD_BITS-1:0] hi_i,
  output logic                                           tok_o,
  output logic      [MAX_DIMENSIONS-1:0][COORD_BITS-1:0] lo_o,
  output logic      [MAX_DIMENSIONS-1:0][COORD_BITS-1:0] hi_o,
  output logic                                           hit_o
);

  logic [MAX_DIMENSIONS-1:0][COORD_BITS-1:0] sub_lo_r, sub_hi_r;
  logic [MAX_DIMENSIONS-1:0][COORD_BITS-1:0] lo_r, hi_r;
  logic                                      tok_r;
  logic                                      hit_r;
  logic [MAX_DIMENSIONS-1:0]                 dim_ok;
  logic                                      slot_sel;

  assign slot_sel = load_i.en && (load_i.slot == eom_pkg::IDX_W'(SLOT));

  // closed intervals: touching bounds overlap; disabled dimensions pass
  always_comb begin
    for (int d = 0; d < MAX_DIMENSIONS; d++) begin
      dim_ok[d] = !dim_en_i[d] || ((sub_lo_r[d] <= hi_i[d]) && (lo_i[d] <= sub_hi_r[d]));
    end
  end

  always_ff @(posedge clk) begin
    if (slot_sel) begin
      sub_lo_r <= wr_lo_i;
      sub_hi_r <= wr_hi_i;
    end
    if (tok_i) begin
      hit_r <= &dim_ok;
    end
    lo_r <= lo_i;
    hi_r <= hi_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else begin
      tok_r <= tok_i;
    end
  end

  assign tok_o = tok_r;
  assign lo_o  = lo_r;
  assign hi_o  = hi_r;
  assign hit_o = hit_r;

endmodule
`default_nettype wire

### design/extent_overlap_matcher.sv
// Extent overlap matcher: a row of subscription cells matched against update extents.
//
// Input channel in_*: in_tuser is the mode (0 load, 1 match). A load transfer
// writes its bounds into the subscription slot named by extent_index (slots at
// or past MAX_SUBSCRIPTIONS are dropped); loads may follow each other in every
// cycle while no match holds the row. A match transfer sends the update extent down
// the cell row, one cell per cycle; each cell records whether its subscription
// overlaps. At the end of the row a pending flag is set, then the result moves
// into the output register on out_*. While a match is in the row in_tready is
// low, so no item is taken until the match leaves the row; the row length sets the wait.
// The output register frees the row as soon as the result is moved into it,
// so the next item is taken while that result still waits on out_tready.
// A stalled receiver holds the result; a finished match then waits at the end
// of the row and in_tready stays low until the output register drains.
// Configuration writes (cfg_*) are registered; the user must make them while idle,
// as the block itself has no check for it. Reset (rst_n low, synchronous) empties
// the row and the output register and sets subscription_count to 0, dimension_count
// to 1; stored extents are kept and must be loaded before use.
`default_nettype none
module extent_overlap_matcher #(
  parameter int MAX_SUBSCRIPTIONS = 64,
  parameter int MAX_DIMENSIONS    = 4,
  parameter int COORD_BITS        = 32
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // extent_index[15:0], lower_0, upper_0, lower_1, upper_1, ..., upper_3 (32 each)
  input  wire logic [eom_pkg::IN_DATA_W-1:0]        in_tdata,
  // mode[0]
  input  wire logic                                 in_tuser,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // update_index[15:0], overlap_mask[79:16], any_overlap[80], zero pad[87:81]
  output logic      [eom_pkg::OUT_DATA_W-1:0]       out_tdata,
  input  wire logic                                 cfg_we,
  input  wire logic [eom_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  wire logic [eom_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int N  = MAX_SUBSCRIPTIONS;
  localparam int D  = MAX_DIMENSIONS;
  localparam int CB = COORD_BITS;

  logic [eom_pkg::SUB_COUNT_W-1:0] sub_count_r;
  logic [eom_pkg::DIM_COUNT_W-1:0] dim_count_r;
  logic [eom_pkg::SUB_COUNT_W-1:0] count_eff;
  logic [eom_pkg::DIM_COUNT_W-1:0] dims_eff;
  logic [D-1:0]                    dim_en;
  logic [eom_pkg::MASK_W-1:0]      cnt_mask;

  logic                            busy_r, busy_nxt;
  logic                            pend_r, pend_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [eom_pkg::IDX_W-1:0]       idx_r;
  logic [eom_pkg::OUT_DATA_W-1:0]  out_data_r;

  logic                            in_acc, match_acc, xfer;
  logic [eom_pkg::IDX_W-1:0]       in_idx;
  logic [D-1:0][CB-1:0]            in_lo, in_hi;
  eom_pkg::load_ctl_t              load_ctl;

  logic [N:0]                      tok_c;
  logic [D-1:0][CB-1:0]            lo_c [0:N];
  logic [D-1:0][CB-1:0]            hi_c [0:N];
  logic [N-1:0]                    hits;
  logic [eom_pkg::MASK_W-1:0]      mask;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_count_r <= '0;
      dim_count_r <= eom_pkg::DIM_COUNT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        eom_pkg::REG_SUBSCRIPTION_COUNT: sub_count_r <= cfg_data[eom_pkg::SUB_COUNT_W-1:0];
        eom_pkg::REG_DIMENSION_COUNT:    dim_count_r <= cfg_data[eom_pkg::DIM_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign count_eff = (sub_count_r > eom_pkg::SUB_COUNT_W'(N)) ?
                     eom_pkg::SUB_COUNT_W'(N) : sub_count_r;
  assign dims_eff  = (dim_count_r > eom_pkg::DIM_COUNT_W'(D)) ?
                     eom_pkg::DIM_COUNT_W'(D) : dim_count_r;

  always_comb begin
    for (int d = 0; d < D; d++) begin
      dim_en[d] = eom_pkg::DIM_COUNT_W'(d) < dims_eff;
    end
    for (int s = 0; s < eom_pkg::MASK_W; s++) begin
      cnt_mask[s] = eom_pkg::SUB_COUNT_W'(s) < count_eff;
    end
  end

  // ---------------- input side ----------------
  assign in_tready = !busy_r;
  assign in_acc    = in_tvalid && in_tready;
  assign match_acc = in_acc && (in_tuser == eom_pkg::MODE_MATCH);
  assign in_idx    = in_tdata[eom_pkg::IDX_W-1:0];

  // bounds keep their low COORD_BITS bits (zero-extended when wider)
  always_comb begin
    for (int d = 0; d < D; d++) begin
      in_lo[d] = CB'(in_tdata[eom_pkg::IDX_W + 2*d*eom_pkg::FIELD_W +: eom_pkg::FIELD_W]);
      in_hi[d] = CB'(in_tdata[eom_pkg::IDX_W + (2*d+1)*eom_pkg::FIELD_W +: eom_pkg::FIELD_W]);
    end
  end

  assign load_ctl.en   = in_acc && (in_tuser == eom_pkg::MODE_LOAD) &&
                         (in_idx < eom_pkg::IDX_W'(N));
  assign load_ctl.slot = in_idx;

  // ---------------- cell row ----------------
  assign tok_c[0] = match_acc;
  assign lo_c[0]  = in_lo;
  assign hi_c[0]  = in_hi;

  for (genvar i = 0; i < N; i++) begin : g_cell
    eom_cell #(
      .SLOT           (i),
      .MAX_DIMENSIONS (D),
      .COORD_BITS     (CB)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .load_i   (load_ctl),
      .wr_lo_i  (in_lo),
      .wr_hi_i  (in_hi),
      .dim_en_i (dim_en),
      .tok_i    (tok_c[i]),
      .lo_i     (lo_c[i]),
      .hi_i     (hi_c[i]),
      .tok_o    (tok_c[i+1]),
      .lo_o     (lo_c[i+1]),
      .hi_o     (hi_c[i+1]),
      .hit_o    (hits[i])
    );
  end

  assign mask = eom_pkg::MASK_W'(hits) & cnt_mask;

  // ---------------- sequencing and output register ----------------
  assign xfer = pend_r && (!out_valid_r || out_tready);

  always_comb begin
    busy_nxt      = busy_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    if (match_acc) begin
      busy_nxt = 1'b1;
    end
    if (tok_c[N]) begin
      pend_nxt = 1'b1;
    end
    if (xfer) begin
      busy_nxt      = 1'b0;
      pend_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (match_acc) begin
      idx_r <= in_idx;
    end
    if (xfer) begin
      out_data_r <= {7'd0, (mask != '0), mask, idx_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

### design/eom_checker.sv
// Port-level checker for the extent overlap matcher, bound to the top level.
`default_nettype none
`include "extent_overlap_matcher_macros.svh"
module eom_checker (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            in_tvalid,
  input wire logic                            in_tready,
  input wire logic                            in_tuser,
  input wire logic                            out_tvalid,
  input wire logic                            out_tready,
  input wire logic [eom_pkg::OUT_DATA_W-1:0]  out_tdata
);

  logic match_xfer;
  logic load_xfer;
  logic out_stall;
  logic mask_nonzero;

  assign match_xfer   = in_tvalid && in_tready && (in_tuser == eom_pkg::MODE_MATCH);
  assign load_xfer    = in_tvalid && in_tready && (in_tuser == eom_pkg::MODE_LOAD);
  assign out_stall    = out_tvalid && !out_tready;
  assign mask_nonzero = (out_tdata[79:16] != 64'd0);

  // flag must agree with the mask it summarizes
  `EOM_ASSERT_NOW(a_any_matches_mask, clk, rst_n, out_tvalid, out_tdata[80] == mask_nonzero)

  // a match occupies the cell row, so the next cycle takes no item
  `EOM_ASSERT_NEXT(a_match_blocks_input, clk, rst_n, match_xfer, !in_tready)

  // a load transfer never yields a result of its own
  `EOM_ASSERT_NEXT(a_load_no_result, clk, rst_n, load_xfer && !out_tvalid, !out_tvalid)

  // stalled result holds
  `EOM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_tdata))

  // reset empties the output register
  `EOM_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, !rst_n, !out_tvalid)

endmodule

bind extent_overlap_matcher eom_checker u_eom_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire

### bench/extent_overlap_matcher_test.sv
// Self-checking testbench for extent_overlap_matcher: directed and random extents, scoreboarded.
`default_nettype none
module extent_overlap_matcher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS         = 64;
  localparam int SLOT_W        = $clog2(SLOTS);
  localparam int DIMS          = 4;
  localparam int ROW_LATENCY   = SLOTS + 6;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int STALL_CYCLES  = 400;
  localparam int PHASE_ITEMS   = 420;
  localparam logic [eom_pkg::CFG_INDEX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [eom_pkg::CFG_INDEX_W-1:0] REG_UNUSED_3 = 2'd3;

  typedef struct packed {
    logic [DIMS-1:0][eom_pkg::FIELD_W-1:0] hi;
    logic [DIMS-1:0][eom_pkg::FIELD_W-1:0] lo;
  } extent_t;

  typedef struct packed {
    logic [eom_pkg::IDX_W-1:0]  update_index;
    logic [eom_pkg::MASK_W-1:0] overlap_mask;
    logic                       any_overlap;
  } match_result_t;

  logic                            clk        = 1'b0;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  // extent_index[15:0], lower_0, upper_0, lower_1, upper_1, ..., upper_3 (32 each)
  logic [eom_pkg::IN_DATA_W-1:0]   in_tdata   = '0;
  // mode[0]
  logic                            in_tuser   = eom_pkg::MODE_LOAD;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // update_index[15:0], overlap_mask[79:16], any_overlap[80], zero pad[87:81]
  logic [eom_pkg::OUT_DATA_W-1:0]  out_tdata;
  logic                            cfg_we     = 1'b0;
  logic [eom_pkg::CFG_INDEX_W-1:0] cfg_index  = '0;
  logic [eom_pkg::CFG_DATA_W-1:0]  cfg_data   = '0;

  // shadow copy of the subscription store and registers
  logic [eom_pkg::FIELD_W-1:0]     shadow_lo [SLOTS][DIMS];
  logic [eom_pkg::FIELD_W-1:0]     shadow_hi [SLOTS][DIMS];
  logic [eom_pkg::SUB_COUNT_W-1:0] active_slots = '0;
  logic [eom_pkg::DIM_COUNT_W-1:0] active_dims  = 3'd1;

  match_result_t pending_matches[$];
  int unsigned   cycle_count    = 0;
  int            mismatch_count = 0;
  int            send_idle_pct  = 0;
  int            recv_idle_pct  = 0;
  int            stall_request  = 0;
  int            stall_served   = 0;
  int            stall_left     = 0;

  extent_overlap_matcher u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: random backpressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (stall_request != stall_served) begin
      stall_served <= stall_request;
      stall_left   <= STALL_CYCLES;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("MISMATCH cycle %0d: %s", cycle_count, msg);
  endtask

  always @(posedge clk) begin : check_output
    match_result_t got;
    match_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.update_index = out_tdata[15:0];
      got.overlap_mask = out_tdata[79:16];
      got.any_overlap  = out_tdata[80];
      if (pending_matches.size() == 0) begin
        report_mismatch($sformatf("result transfer with nothing pending, index %h",
                                  got.update_index));
      end else begin
        want = pending_matches.pop_front();
        if (got.update_index !== want.update_index)
          report_mismatch($sformatf("update_index got %h want %h",
                                    got.update_index, want.update_index));
        if (got.overlap_mask !== want.overlap_mask)
          report_mismatch($sformatf("overlap_mask got %h want %h (index %h)",
                                    got.overlap_mask, want.overlap_mask, want.update_index));
        if (got.any_overlap !== want.any_overlap)
          report_mismatch($sformatf("any_overlap got %b want %b (index %h)",
                                    got.any_overlap, want.any_overlap, want.update_index));
      end
    end
  end

  function automatic logic [eom_pkg::MASK_W-1:0] predict_overlap(input extent_t upd);
    int n_slots;
    int n_dims;
    logic hit;
    logic [eom_pkg::MASK_W-1:0] mask;
    n_slots = (active_slots > SLOTS) ? SLOTS : active_slots;
    n_dims  = (active_dims > DIMS) ? DIMS : active_dims;
    mask    = '0;
    for (int s = 0; s < n_slots; s++) begin
      hit = 1'b1;
      for (int d = 0; d < n_dims; d++)
        if (!(shadow_lo[s][d] <= upd.hi[d] && upd.lo[d] <= shadow_hi[s][d])) hit = 1'b0;
      mask[s] = hit;
    end
    return mask;
  endfunction

  function automatic logic [eom_pkg::IN_DATA_W-1:0] pack_extent(
      input logic [eom_pkg::IDX_W-1:0] idx, input extent_t ext);
    logic [eom_pkg::IN_DATA_W-1:0] v;
    v = '0;
    v[eom_pkg::IDX_W-1:0] = idx;
    for (int d = 0; d < DIMS; d++) begin
      v[eom_pkg::IDX_W + 2*eom_pkg::FIELD_W*d +: eom_pkg::FIELD_W] = ext.lo[d];
      v[eom_pkg::IDX_W + 2*eom_pkg::FIELD_W*d + eom_pkg::FIELD_W +: eom_pkg::FIELD_W] =
        ext.hi[d];
    end
    return v;
  endfunction

  function automatic logic [eom_pkg::FIELD_W-1:0] pick_coord();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom;
      default: return $urandom_range(1000);
    endcase
  endfunction

  // mostly ordered intervals near each other so overlaps are common
  function automatic extent_t pick_extent();
    extent_t e;
    for (int d = 0; d < DIMS; d++) begin
      e.lo[d] = pick_coord();
      if ($urandom_range(3) == 0) e.hi[d] = pick_coord();
      else e.hi[d] = e.lo[d] + $urandom_range(400);
    end
    return e;
  endfunction

  function automatic extent_t make_box(input logic [eom_pkg::FIELD_W-1:0] lo,
                                       input logic [eom_pkg::FIELD_W-1:0] hi);
    extent_t e;
    for (int d = 0; d < DIMS; d++) begin
      e.lo[d] = lo;
      e.hi[d] = hi;
    end
    return e;
  endfunction

  task automatic send_extent(input logic mode, input logic [eom_pkg::IDX_W-1:0] idx,
                             input extent_t ext);
    logic [eom_pkg::MASK_W-1:0] mask;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= pack_extent(idx, ext);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // transfer taken at this edge
    if (mode == eom_pkg::MODE_MATCH) begin
      mask = predict_overlap(ext);
      pending_matches.push_back('{update_index: idx, overlap_mask: mask,
                                  any_overlap: (mask != '0)});
    end else if (idx < SLOTS) begin
      for (int d = 0; d < DIMS; d++) begin
        shadow_lo[idx[SLOT_W-1:0]][d] = ext.lo[d];
        shadow_hi[idx[SLOT_W-1:0]][d] = ext.hi[d];
      end
    end
  endtask

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 50)
      send_extent(eom_pkg::MODE_MATCH, eom_pkg::IDX_W'($urandom), pick_extent());
    else if (pick < 95)
      send_extent(eom_pkg::MODE_LOAD, eom_pkg::IDX_W'($urandom_range(SLOTS-1)),
                  pick_extent());
    else
      send_extent(eom_pkg::MODE_LOAD, eom_pkg::IDX_W'($urandom_range(65535, SLOTS)),
                  pick_extent());
  endtask

  // idle the input, collect all results, then let the row empty
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (ROW_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [eom_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [eom_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == eom_pkg::REG_SUBSCRIPTION_COUNT)
      active_slots = val[eom_pkg::SUB_COUNT_W-1:0];
    else if (idx == eom_pkg::REG_DIMENSION_COUNT)
      active_dims = val[eom_pkg::DIM_COUNT_W-1:0];
    @(posedge clk);
  endtask

  task automatic test_slot_fill();
    // reset count is zero, so nothing is compared yet
    send_extent(eom_pkg::MODE_MATCH, 16'h0000, make_box('0, '1));
    for (int s = 0; s < SLOTS; s++)
      send_extent(eom_pkg::MODE_LOAD, eom_pkg::IDX_W'(s), pick_extent());
    drain();
  endtask

  task automatic test_directed_cases();
    write_reg(eom_pkg::REG_SUBSCRIPTION_COUNT, eom_pkg::CFG_DATA_W'(SLOTS));
    send_extent(eom_pkg::MODE_LOAD, 16'd0, make_box('0, '1));
    send_extent(eom_pkg::MODE_LOAD, 16'd1, make_box(100, 50));     // inverted interval
    send_extent(eom_pkg::MODE_LOAD, 16'd2, make_box(10, 20));
    send_extent(eom_pkg::MODE_LOAD, eom_pkg::IDX_W'(SLOTS-1), make_box('1, '1));
    // loads past the store are dropped
    send_extent(eom_pkg::MODE_LOAD, eom_pkg::IDX_W'(SLOTS), make_box('0, '0));
    send_extent(eom_pkg::MODE_LOAD, 16'hFFFF, make_box('0, '0));
    // dimension count still at its reset value
    send_extent(eom_pkg::MODE_MATCH, 16'hFFFF, make_box(20, 30));
    drain();
    write_reg(eom_pkg::REG_DIMENSION_COUNT, eom_pkg::CFG_DATA_W'(DIMS));
    send_extent(eom_pkg::MODE_MATCH, 16'h0001, make_box(20, 30));   // touches slot 2 upper
    send_extent(eom_pkg::MODE_MATCH, 16'h0002, make_box(0, 10));    // touches slot 2 lower
    send_extent(eom_pkg::MODE_MATCH, 16'h0003, make_box(21, 30));
    send_extent(eom_pkg::MODE_MATCH, 16'h0004, make_box('0, '0));
    send_extent(eom_pkg::MODE_MATCH, 16'h0005, make_box('1, '1));
    send_extent(eom_pkg::MODE_MATCH, 16'h0006, make_box(30, 5));    // inverted update
    drain();
    // zero dimensions: every counted slot overlaps
    write_reg(eom_pkg::REG_DIMENSION_COUNT, 7'd0);
    send_extent(eom_pkg::MODE_MATCH, 16'h0007, pick_extent());
    drain();
    write_reg(eom_pkg::REG_DIMENSION_COUNT, 7'd7);
    send_extent(eom_pkg::MODE_MATCH, 16'h0008, pick_extent());
    drain();
    write_reg(eom_pkg::REG_SUBSCRIPTION_COUNT, 7'h7F);
    send_extent(eom_pkg::MODE_MATCH, 16'h0009, make_box(0, 500));
    drain();
    write_reg(REG_UNUSED_2, 7'h7F);
    write_reg(REG_UNUSED_3, 7'h00);
    send_extent(eom_pkg::MODE_MATCH, 16'h000A, make_box(0, 500));
    drain();
    write_reg(eom_pkg::REG_SUBSCRIPTION_COUNT, 7'd0);
    send_extent(eom_pkg::MODE_MATCH, 16'h000B, make_box('0, '1));
    drain();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input int slots_sel, input int dims_sel);
    write_reg(eom_pkg::REG_SUBSCRIPTION_COUNT, eom_pkg::CFG_DATA_W'(slots_sel));
    write_reg(eom_pkg::REG_DIMENSION_COUNT, eom_pkg::CFG_DATA_W'(dims_sel));
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (PHASE_ITEMS) send_random_item();
    drain();
  endtask

  // receiver holds off while the sender keeps offering, so the row backs up
  task automatic test_output_stall();
    write_reg(eom_pkg::REG_SUBSCRIPTION_COUNT, eom_pkg::CFG_DATA_W'(SLOTS));
    write_reg(eom_pkg::REG_DIMENSION_COUNT, eom_pkg::CFG_DATA_W'($urandom_range(DIMS, 1)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    stall_request++;
    repeat (30) send_random_item();
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_slot_fill();
    test_directed_cases();
    test_random_traffic(13, 83, SLOTS, DIMS);
    test_random_traffic(83, 13, $urandom_range(SLOTS-1, 1), $urandom_range(DIMS, 1));
    test_random_traffic(0, 0, $urandom_range(127, 1), $urandom_range(7, 1));
    test_output_stall();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

### extent_overlap_matcher.f
+incdir+design
design/eom_pkg.sv
design/eom_cell.sv
design/extent_overlap_matcher.sv
design/eom_checker.sv
bench/extent_overlap_matcher_test.sv
